// ===== rtl/rvc_pkg.sv =====
// ---------------------------------------------------------------------------
// rvc_pkg
// Shared types and constants of the RV32I instruction core.
// ---------------------------------------------------------------------------
package rvc_pkg;

	localparam int unsigned MemBytes = 262144;
	localparam int unsigned MemAw    = $clog2(MemBytes);
	localparam int unsigned LoadAw   = 18;

	localparam logic [31:0] HaltWord = 32'h00c68223;

	localparam logic [6:0] OpReg    = 7'd51;
	localparam logic [6:0] OpImm    = 7'd19;
	localparam logic [6:0] OpBranch = 7'd99;
	localparam logic [6:0] OpJal    = 7'd111;
	localparam logic [6:0] OpJalr   = 7'd103;
	localparam logic [6:0] OpLui    = 7'd55;
	localparam logic [6:0] OpAuipc  = 7'd23;
	localparam logic [6:0] OpStore  = 7'd35;
	localparam logic [6:0] OpLoad   = 7'd3;

	localparam logic OpcodeLoadByte = 1'b0;
	localparam logic OpcodeStep     = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic       clear;      // clearing pass write
		logic       load_wr;    // byte load item write
		logic       mem_rd;     // issue byte read
		logic [1:0] byte_idx;   // byte of the access
		logic [1:0] cap_idx;    // byte of the read data being captured
		logic       fetch;      // read addressed by pc
		logic       cap_ir;     // capture fetched byte into instruction
		logic       cap_data;   // capture fetched byte into load data
		logic       exec;       // decode and compute, latch operands
		logic       st_wr;      // write one store byte
		logic       commit;     // register writeback and pc update
		logic       halt;       // set halt flag
	} rvc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       is_halt;
		logic       is_load;
		logic       is_store;
		logic [2:0] nbytes;     // bytes of the memory access
		logic       halted;
	} rvc_sts_t;

endpackage

// ===== rtl/rvc_in_if.sv =====
// ---------------------------------------------------------------------------
// rvc_in_if / rvc_out_if
// Valid/ready channels of the core.
// ---------------------------------------------------------------------------
interface rvc_in_if;
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [17:0]           load_address;
	logic [7:0]            load_byte;
	modport source (output valid, opcode, load_address, load_byte, input ready);
	modport sink (input valid, opcode, load_address, load_byte, output ready);
endinterface

interface rvc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_pc;
	logic        halted;
	logic [7:0]  exit_code;
	modport source (output valid, next_pc, halted, exit_code, input ready);
	modport sink (input valid, next_pc, halted, exit_code, output ready);
endinterface

// ===== rtl/rvc_ram.sv =====
// ---------------------------------------------------------------------------
// rvc_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module rvc_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/rvc_datapath.sv =====
// ---------------------------------------------------------------------------
// rvc_datapath
// Register file, pc, instruction and operand registers, ALU and byte memory.
// ---------------------------------------------------------------------------
module rvc_datapath import rvc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  rvc_cmd_t           cmd,
	input  logic [MemAw-1:0]   clr_addr,
	input  logic [LoadAw-1:0]  load_address,
	input  logic [7:0]         load_byte,
	output rvc_sts_t           sts,
	output logic [31:0]        pc,
	output logic [7:0]         exit_code
);
	logic [31:0] pc_q;
	logic [31:0] ir_q;
	logic [31:0] rf_q [32];
	logic [31:0] addr_q;     // data address
	logic [31:0] sdata_q;    // store data
	logic [31:0] ldata_q;    // load bytes
	logic [31:0] res_q;
	logic        wr_q;
	logic [31:0] npc_q;
	logic        halt_q;
	logic [31:0] ldres;

	logic [MemAw-1:0] m_addr;
	logic             m_we;
	logic [7:0]       m_wdata, m_rdata;
	logic [31:0]      byte_addr;

	// memory port
	always_comb begin
		byte_addr = (cmd.fetch ? pc_q : addr_q) + {30'd0, cmd.byte_idx};
		m_we      = cmd.clear | cmd.load_wr | cmd.st_wr;
		m_wdata   = 8'd0;
		m_addr    = byte_addr[MemAw-1:0];
		if (cmd.clear) begin
			m_addr = clr_addr;
		end else if (cmd.load_wr) begin
			m_addr  = MemAw'(load_address);
			m_wdata = load_byte;
		end else if (cmd.st_wr) begin
			m_wdata = sdata_q[8*cmd.byte_idx +: 8];
		end
	end

	rvc_ram #(.Width(8), .Depth(MemBytes)) u_mem (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
	);

	// decode
	logic [6:0]  op;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic        alt;
	logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, imm_u;
	always_comb begin
		op    = ir_q[6:0];
		rd    = ir_q[11:7];
		f3    = ir_q[14:12];
		alt   = ir_q[30];
		a     = rf_q[ir_q[19:15]];
		b     = rf_q[ir_q[24:20]];
		imm_i = {{20{ir_q[31]}}, ir_q[31:20]};
		imm_s = {{20{ir_q[31]}}, ir_q[31:25], ir_q[11:7]};
		imm_b = {{20{ir_q[31]}}, ir_q[7], ir_q[30:25], ir_q[11:8], 1'b0};
		imm_j = {{12{ir_q[31]}}, ir_q[19:12], ir_q[20], ir_q[30:21], 1'b0};
		imm_u = {ir_q[31:12], 12'd0};
	end

	// ALU
	logic [31:0] alu_b, alu_y;
	logic        alu_alt;
	always_comb begin
		alu_b   = (op == OpReg) ? b : imm_i;
		alu_alt = alt & ((op == OpReg) | (f3 == 3'd5));
		case (f3)
			3'd0:    alu_y = alu_alt ? a - alu_b : a + alu_b;
			3'd1:    alu_y = a << alu_b[4:0];
			3'd2:    alu_y = {31'd0, $signed(a) < $signed(alu_b)};
			3'd3:    alu_y = {31'd0, a < alu_b};
			3'd4:    alu_y = a ^ alu_b;
			3'd5:    alu_y = alu_alt ? 32'($signed(a) >>> alu_b[4:0]) : a >> alu_b[4:0];
			3'd6:    alu_y = a | alu_b;
			default: alu_y = a & alu_b;
		endcase
	end

	// next pc and result
	logic        taken;
	logic [31:0] npc, res;
	logic        wr;
	always_comb begin
		case (f3)
			3'd0:    taken = a == b;
			3'd1:    taken = a != b;
			3'd4:    taken = $signed(a) < $signed(b);
			3'd5:    taken = $signed(a) >= $signed(b);
			3'd6:    taken = a < b;
			3'd7:    taken = a >= b;
			default: taken = 1'b0;
		endcase
		npc = pc_q + 32'd4;
		res = alu_y;
		wr  = 1'b0;
		case (op)
			OpReg, OpImm: wr = 1'b1;
			OpLoad: wr = (f3 == 3'd0) | (f3 == 3'd1) | (f3 == 3'd2) |
				(f3 == 3'd4) | (f3 == 3'd5);
			OpBranch: if (taken) npc = pc_q + imm_b;
			OpJal: begin
				res = pc_q + 32'd4; wr = 1'b1; npc = pc_q + imm_j;
			end
			OpJalr: begin
				res = pc_q + 32'd4; wr = 1'b1; npc = (a + imm_i) & ~32'd1;
			end
			OpLui: begin
				res = imm_u; wr = 1'b1;
			end
			OpAuipc: begin
				res = pc_q + imm_u; wr = 1'b1;
			end
			default: ;
		endcase
	end

	// load result extension
	always_comb begin
		case (f3)
			3'd0:    ldres = {{24{ldata_q[7]}}, ldata_q[7:0]};
			3'd1:    ldres = {{16{ldata_q[15]}}, ldata_q[15:0]};
			3'd4:    ldres = {24'd0, ldata_q[7:0]};
			3'd5:    ldres = {16'd0, ldata_q[15:0]};
			default: ldres = ldata_q;
		endcase
	end

	// status
	always_comb begin
		sts.is_halt  = ir_q == HaltWord;
		sts.is_load  = (op == OpLoad) & wr;
		sts.is_store = (op == OpStore) & (f3 < 3'd3);
		case (f3[1:0])
			2'd0:    sts.nbytes = 3'd1;
			2'd1:    sts.nbytes = 3'd2;
			default: sts.nbytes = 3'd4;
		endcase
		sts.halted = halt_q;
	end

	// operand and capture registers
	always_ff @(posedge clk) begin
		if (cmd.cap_ir) ir_q[8*cmd.cap_idx +: 8] <= m_rdata;
		if (cmd.cap_data) ldata_q[8*cmd.cap_idx +: 8] <= m_rdata;
		if (cmd.exec) begin
			addr_q  <= a + ((op == OpStore) ? imm_s : imm_i);
			sdata_q <= b;
			res_q   <= res;
			wr_q    <= wr;
			npc_q   <= npc;
			ldata_q <= 32'd0;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= 32'd0;
			halt_q <= 1'b0;
			for (int i = 0; i < 32; i++) rf_q[i] <= 32'd0;
		end else begin
			if (cmd.halt) halt_q <= 1'b1;
			if (cmd.commit) begin
				pc_q <= npc_q;
				if (wr_q && rd != 5'd0) rf_q[rd] <= (op == OpLoad) ? ldres : res_q;
			end
		end
	end

	assign pc        = pc_q;
	assign exit_code = halt_q ? rf_q[10][7:0] : 8'd0;

`ifndef SYNTHESIS
	a_x0_zero: assert property (@(posedge clk) disable iff (!arst_n) rf_q[0] == 32'd0)
		else $error("x0 not zero");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q) else $error("halt flag cleared");
	a_halt_pc: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> $stable(pc_q)) else $error("pc moved while halted");
`endif
endmodule

// ===== rtl/rvc_control.sv =====
// ---------------------------------------------------------------------------
// rvc_control
// Sequencer: clearing pass, byte loads and the multicycle instruction steps.
// ---------------------------------------------------------------------------
module rvc_control import rvc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_opcode,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  rvc_sts_t         sts,
	output rvc_cmd_t         cmd,
	output logic [MemAw-1:0] clr_addr
);
	typedef enum logic [7:0] {
		S_CLEAR = 8'b00000001,
		S_IDLE  = 8'b00000010,
		S_FETCH = 8'b00000100,
		S_EXEC  = 8'b00001000,
		S_MEM   = 8'b00010000,
		S_WB    = 8'b00100000,
		S_RESP  = 8'b01000000,
		S_LDW   = 8'b10000000
	} state_t;

	state_t           state_q, state_d;
	logic [MemAw-1:0] clr_q;
	logic [2:0]       cnt_q, cnt_d;   // byte being issued
	logic             rd_pend_q;      // read issued in the previous cycle
	logic [1:0]       rd_idx_q;
	logic             accept;

	assign accept   = in_valid & in_ready;
	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_RESP;
	assign clr_addr = clr_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.cap_ir   = rd_pend_q & (state_q == S_FETCH);
		cmd.cap_data = rd_pend_q & (state_q == S_MEM);
		cmd.cap_idx  = rd_idx_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (clr_q == MemAw'(MemBytes - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				cnt_d = 3'd0;
				if (accept) begin
					if (in_opcode == OpcodeLoadByte) begin
						cmd.load_wr = 1'b1;
						state_d = S_RESP;
					end else if (sts.halted) begin
						state_d = S_RESP;
					end else begin
						state_d = S_FETCH;
					end
				end
			end
			S_FETCH: begin
				if (cnt_q < 3'd4) begin
					cmd.mem_rd = 1'b1; cmd.fetch = 1'b1;
					cmd.byte_idx = cnt_q[1:0];
					cnt_d = cnt_q + 3'd1;
				end else if (!rd_pend_q) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cnt_d = 3'd0;
				if (sts.is_halt) begin
					cmd.halt = 1'b1;
					state_d = S_RESP;
				end else begin
					cmd.exec = 1'b1;
					state_d = S_MEM;
				end
			end
			S_MEM: begin
				if ((sts.is_load | sts.is_store) && cnt_q < sts.nbytes) begin
					cmd.byte_idx = cnt_q[1:0];
					if (sts.is_load) cmd.mem_rd = 1'b1;
					else cmd.st_wr = 1'b1;
					cnt_d = cnt_q + 3'd1;
				end else if (!rd_pend_q) begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				cmd.commit = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: if (out_ready) state_d = S_IDLE;
			S_LDW: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			cnt_q     <= 3'd0;
			rd_pend_q <= 1'b0;
			rd_idx_q  <= 2'd0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			rd_pend_q <= cmd.mem_rd;
			rd_idx_q  <= cmd.byte_idx;
			if (state_q == S_CLEAR) clr_q <= clr_q + MemAw'(1);
		end
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE)) else $error("accept without leaving idle");
	a_no_wr_rd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mem_rd && (cmd.st_wr || cmd.load_wr || cmd.clear)))
		else $error("memory read and write collide");
`endif
endmodule

// ===== rtl/rv32i_instruction_core.sv =====
// Timing: a byte load item has its result valid the cycle after the transfer; a step item
//   passes through fetch, execute, data access and writeback; a halt word ends after execute.
// Throughput: one item at a time; the next input is taken the cycle after the result is accepted.
// Reset: asynchronous, clears the register file, pc and halt flag, then a clearing pass over
//   all MemBytes (262144) addresses zeroes the memory while no item is accepted.
// ---------------------------------------------------------------------------
// rv32i_instruction_core
// Multicycle RV32I integer core with a byte-wide data and instruction memory.
// ---------------------------------------------------------------------------
module rv32i_instruction_core import rvc_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	rvc_in_if.sink    in_ch,
	rvc_out_if.source out_ch
);
	rvc_cmd_t         cmd;
	rvc_sts_t         sts;
	logic [MemAw-1:0] clr_addr;

	rvc_control u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_opcode(in_ch.opcode), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd), .clr_addr(clr_addr)
	);

	rvc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .clr_addr(clr_addr),
		.load_address(in_ch.load_address), .load_byte(in_ch.load_byte),
		.sts(sts), .pc(out_ch.next_pc), .exit_code(out_ch.exit_code)
	);

	assign out_ch.halted = sts.halted;
endmodule
